// ===== hdl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Task tick scheduler package
// Shared constants, codes and the slot record type.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int ID_W      = 16;
    localparam int PRIO_W    = 3;
    localparam int LEN_W     = 16;
    localparam int TIME_W    = 32;
    localparam int SLICE_W   = 8;
    localparam int SW_W      = 32;
    localparam int SCORE_W   = 17;
    localparam int BATCH_WEIGHT = 1000;
    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(4);

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_TICK     = 3'd1;
    localparam logic [2:0] OP_BLOCK    = 3'd2;
    localparam logic [2:0] OP_WAKE     = 3'd3;
    localparam logic [2:0] OP_KILL     = 3'd4;
    localparam logic [2:0] OP_STOP     = 3'd5;
    localparam logic [2:0] OP_CONTINUE = 3'd6;
    localparam logic [2:0] OP_SETPRIO  = 3'd7;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;

    localparam logic [1:0] POL_RR    = 2'd0;
    localparam logic [1:0] POL_FIFO  = 2'd1;
    localparam logic [1:0] POL_BATCH = 2'd2;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_SLICE  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [1:0]         status;
        logic               stopped;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  arrival;
        logic [LEN_W-1:0]   total;
        logic [LEN_W-1:0]   used;
        logic [SLICE_W-1:0] slice;
        logic [TIME_W-1:0]  wake;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    typedef struct packed {
        logic       clear;
        logic       load;
        logic [1:0] policy;
    } t_pick_ctl;

endpackage

// ===== hdl/tts_req_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one scheduler operation.
// ----------------------------------------------------------------------------
interface tts_req_if;
    import tts_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [LEN_W-1:0]  run_length;
    logic [TIME_W-1:0] wake_time;

    modport source (output valid, operation, task_id, priority_req, run_length, wake_time,
                    input ready);
    modport sink (input valid, operation, task_id, priority_req, run_length, wake_time,
                  output ready);
endinterface

// ===== hdl/tts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying one scheduler result.
// ----------------------------------------------------------------------------
interface tts_rsp_if;
    import tts_pkg::*;
    logic            valid;
    logic            ready;
    logic            ok;
    logic [ID_W-1:0] result_id;
    logic [ID_W-1:0] running_id;
    logic [SW_W-1:0] switch_count;

    modport source (output valid, ok, result_id, running_id, switch_count, input ready);
    modport sink (input valid, ok, result_id, running_id, switch_count, output ready);
endinterface

// ===== hdl/tts_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Slot table memory
// Simple dual port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module tts_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hdl/tts_picker.sv =====
// ----------------------------------------------------------------------------
// Task picker
// Keeps the best ready candidate seen during a table scan.
// ----------------------------------------------------------------------------
module tts_picker
    import tts_pkg::*;
(
    input  logic              i_clk,
    input  t_pick_ctl         i_ctl,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_slot             i_rec,
    output logic              o_found,
    output logic [SLOT_W-1:0] o_best
);
    logic                r_found;
    logic [SLOT_W-1:0]   r_best;
    logic [PRIO_W-1:0]   r_prio;
    logic [TIME_W-1:0]   r_arr;
    logic [SCORE_W-1:0]  r_score;
    logic [SCORE_W-1:0]  score;
    logic                better;

    assign score = SCORE_W'(i_rec.prio) * SCORE_W'(BATCH_WEIGHT) + SCORE_W'(i_rec.used);

    always_comb begin
        better = 1'b0;
        case (i_ctl.policy)
            POL_BATCH: better = !r_found || score < r_score;
            POL_FIFO:  better = !r_found || i_rec.arrival < r_arr;
            default:   better = !r_found || i_rec.prio < r_prio ||
                                (i_rec.prio == r_prio && i_rec.arrival < r_arr);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.load && better) begin
            r_found <= 1'b1;
            r_best  <= i_idx;
            r_prio  <= i_rec.prio;
            r_arr   <= i_rec.arrival;
            r_score <= score;
        end
    end

    assign o_found = r_found;
    assign o_best  = r_best;
endmodule

// ===== hdl/task_tick_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Task tick scheduler
// Slot table in RAM, walked by a sequencer that reads, modifies and writes back.
// ----------------------------------------------------------------------------
// A kill, or a tick that retires the running task, shifts the later slots down.
// One request is processed at a time; the scan through the slot RAM's read port sets the pace.
// Synchronous active-low reset empties the table and clears time and counters.
module task_tick_scheduler_unit
    import tts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [SLICE_W-1:0] i_cfg_data,
    tts_req_if.sink            i_req,
    tts_rsp_if.source          o_rsp
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIND   = 4'd1;
    localparam logic [3:0] S_WRBACK = 4'd2;
    localparam logic [3:0] S_BLK_RD = 4'd3;
    localparam logic [3:0] S_BLK_WR = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_PICK   = 4'd6;
    localparam logic [3:0] S_CHG_RD = 4'd7;
    localparam logic [3:0] S_CHG_WR = 4'd8;
    localparam logic [3:0] S_SHIFT  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]         r_state;
    logic [1:0]         r_policy;
    logic [SLICE_W-1:0] r_slice;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ptr;
    logic               r_dv;
    logic [SLOT_W-1:0]  r_didx;
    logic               r_run_vld;
    logic [SLOT_W-1:0]  r_run;
    logic [ID_W-1:0]    r_run_id;
    logic [TIME_W-1:0]  r_time;
    logic [ID_W-1:0]    r_next_id;
    logic [SW_W-1:0]    r_switches;
    logic [2:0]         r_op;
    logic [ID_W-1:0]    r_id;
    logic [PRIO_W-1:0]  r_prio;
    logic [TIME_W-1:0]  r_wake;
    logic [SLOT_W-1:0]  r_k;
    t_slot              r_rec;
    logic               r_ok;
    logic [ID_W-1:0]    r_rid;
    logic               r_rsp_vld;
    logic               r_rsp_ok;
    logic [ID_W-1:0]    r_rsp_rid;
    logic [ID_W-1:0]    r_rsp_run;
    logic [SW_W-1:0]    r_rsp_sw;

    logic               accept;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    t_slot              wr_data;
    logic [SLOT_BITS-1:0] rd_bits;
    t_slot              rec;
    t_slot              new_rec;
    t_slot              scan_rec;
    logic               due;
    logic               scan_end;
    logic               hit;
    logic               rr;
    logic [LEN_W-1:0]   chg_used;
    logic               chg_retire;
    logic               chg_exp;
    logic               full;
    t_pick_ctl          pick_ctl;
    logic               pick_found;
    logic [SLOT_W-1:0]  pick_best;

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign rec      = t_slot'(rd_bits);
    assign full     = (r_count == CNT_W'(MAX_TASKS));
    assign rr       = (r_policy != POL_FIFO) && (r_policy != POL_BATCH);
    assign due      = rec.status == ST_BLOCKED && rec.wake != '0 && r_time >= rec.wake;
    assign scan_end = !rd_en && !r_dv;
    assign hit      = r_dv && rec.id == r_id;
    assign chg_used = rec.used + LEN_W'(1);
    assign chg_retire = chg_used >= rec.total;
    assign chg_exp  = rec.slice <= SLICE_W'(1);

    always_comb begin
        new_rec         = '0;
        new_rec.id      = r_next_id;
        new_rec.status  = ST_READY;
        new_rec.prio    = i_req.priority_req;
        new_rec.arrival = r_time;
        new_rec.total   = (i_req.run_length == '0) ? LEN_W'(1) : i_req.run_length;
        new_rec.slice   = r_slice;
        scan_rec        = rec;
        if (due) begin
            scan_rec.status = ST_READY;
            scan_rec.wake   = '0;
            scan_rec.slice  = r_slice;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rec;
        pick_ctl.clear  = (r_state == S_IDLE);
        pick_ctl.load   = 1'b0;
        pick_ctl.policy = r_policy;
        case (r_state)
            S_IDLE: begin
                wr_en   = accept && i_req.operation == OP_CREATE && !full;
                wr_addr = r_count[SLOT_W-1:0];
                wr_data = new_rec;
            end
            S_FIND, S_SCAN, S_SHIFT: begin
                rd_en   = r_ptr < r_count;
                rd_addr = r_ptr[SLOT_W-1:0];
                if (r_state == S_SCAN) begin
                    wr_en   = r_dv && due;
                    wr_addr = r_didx;
                    wr_data = scan_rec;
                    pick_ctl.load = r_dv && scan_rec.status == ST_READY && !scan_rec.stopped;
                end else if (r_state == S_SHIFT) begin
                    wr_en   = r_dv;
                    wr_addr = r_didx - SLOT_W'(1);
                    wr_data = rec;
                end
            end
            S_WRBACK: begin
                wr_addr = r_k;
                wr_data = r_rec;
                case (r_op)
                    OP_WAKE: begin
                        wr_en = r_rec.status == ST_BLOCKED;
                        wr_data.status = ST_READY;
                        wr_data.wake   = '0;
                        wr_data.slice  = r_slice;
                    end
                    OP_STOP: begin
                        wr_en = 1'b1;
                        wr_data.stopped = 1'b1;
                        if (r_run_vld && r_run == r_k) begin
                            wr_data.status = ST_READY;
                        end
                    end
                    OP_CONTINUE: begin
                        wr_en = 1'b1;
                        wr_data.stopped = 1'b0;
                    end
                    OP_SETPRIO: begin
                        wr_en = 1'b1;
                        wr_data.prio = r_prio;
                    end
                    default: wr_en = 1'b0;
                endcase
            end
            S_BLK_RD, S_CHG_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_run;
            end
            S_BLK_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_run;
                wr_data.status = ST_BLOCKED;
                wr_data.wake   = r_wake;
            end
            S_CHG_WR: begin
                wr_en   = !chg_retire;
                wr_addr = r_run;
                wr_data.status = (rr && chg_exp) ? ST_READY : ST_RUNNING;
                wr_data.used   = chg_used;
                wr_data.slice  = (rr && chg_exp) ? r_slice :
                                 (rec.slice != '0) ? rec.slice - SLICE_W'(1) : rec.slice;
            end
            default: wr_en = 1'b0;
        endcase
    end

    tts_slot_ram #(
        .WIDTH(SLOT_BITS),
        .DEPTH(MAX_TASKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    tts_picker u_pick (
        .i_clk   (i_clk),
        .i_ctl   (pick_ctl),
        .i_idx   (r_didx),
        .i_rec   (scan_rec),
        .o_found (pick_found),
        .o_best  (pick_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_policy   <= POL_RR;
            r_slice    <= SLICE_RESET;
            r_count    <= '0;
            r_dv       <= 1'b0;
            r_run_vld  <= 1'b0;
            r_time     <= '0;
            r_next_id  <= ID_W'(1);
            r_switches <= '0;
            r_rsp_vld  <= 1'b0;
        end else begin
            r_dv   <= rd_en;
            r_didx <= rd_addr;
            if (rd_en && (r_state == S_FIND || r_state == S_SCAN || r_state == S_SHIFT)) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (r_rsp_vld && o_rsp.ready && r_state != S_DONE) begin
                r_rsp_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POLICY) begin
                    r_policy <= i_cfg_data[1:0];
                end else begin
                    r_slice <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    r_ptr <= '0;
                    if (accept) begin
                        r_op   <= i_req.operation;
                        r_id   <= i_req.task_id;
                        r_prio <= i_req.priority_req;
                        r_wake <= i_req.wake_time;
                        r_ok   <= (i_req.operation == OP_TICK) ||
                                  (i_req.operation == OP_CREATE && !full);
                        r_rid  <= (i_req.operation == OP_CREATE && !full) ? r_next_id : '0;
                        case (i_req.operation)
                            OP_CREATE: begin
                                if (!full) begin
                                    r_count <= r_count + CNT_W'(1);
                                    r_next_id <= (r_next_id == '1) ? ID_W'(1)
                                                                   : r_next_id + ID_W'(1);
                                end
                                r_state <= S_DONE;
                            end
                            OP_TICK: begin
                                r_time  <= r_time + TIME_W'(1);
                                r_state <= S_SCAN;
                            end
                            OP_BLOCK: begin
                                r_state <= r_run_vld ? S_BLK_RD : S_DONE;
                            end
                            default: begin
                                r_state <= (i_req.task_id == '0) ? S_DONE : S_FIND;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    if (hit) begin
                        r_k     <= r_didx;
                        r_rec   <= rec;
                        r_state <= S_WRBACK;
                    end else if (scan_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_WRBACK: begin
                    r_ok    <= (r_op != OP_WAKE) || r_rec.status == ST_BLOCKED;
                    r_state <= (r_op == OP_KILL) ? S_SHIFT : S_DONE;
                    if (r_op == OP_KILL) begin
                        r_ptr   <= CNT_W'(r_k) + CNT_W'(1);
                        if (r_run_vld && r_run == r_k) begin
                            r_run_vld <= 1'b0;
                        end else if (r_run_vld && r_run > r_k) begin
                            r_run <= r_run - SLOT_W'(1);
                        end
                    end else if (r_op == OP_STOP && r_run_vld && r_run == r_k) begin
                        r_run_vld <= 1'b0;
                    end
                end
                S_BLK_RD: begin
                    r_state <= S_BLK_WR;
                end
                S_BLK_WR: begin
                    r_ok      <= 1'b1;
                    r_run_vld <= 1'b0;
                    r_state   <= S_DONE;
                end
                S_SCAN: begin
                    if (scan_end) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_run_vld) begin
                        r_state <= S_CHG_RD;
                    end else begin
                        r_switches <= r_switches + SW_W'(1);
                        if (pick_found) begin
                            r_run_vld <= 1'b1;
                            r_run     <= pick_best;
                            r_state   <= S_CHG_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CHG_RD: begin
                    r_state <= S_CHG_WR;
                end
                S_CHG_WR: begin
                    r_run_id <= rec.id;
                    r_state  <= chg_retire ? S_SHIFT : S_DONE;
                    if (chg_retire) begin
                        r_run_vld <= 1'b0;
                        r_ptr     <= CNT_W'(r_run) + CNT_W'(1);
                    end else if (rr && chg_exp) begin
                        r_run_vld <= 1'b0;
                    end
                end
                S_SHIFT: begin
                    if (scan_end) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_rsp_vld || o_rsp.ready) begin
                        r_rsp_vld <= 1'b1;
                        r_rsp_ok  <= r_ok;
                        r_rsp_rid <= r_rid;
                        r_rsp_run <= r_run_vld ? r_run_id : '0;
                        r_rsp_sw  <= r_switches;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_rsp_vld;
    assign o_rsp.ok           = r_rsp_ok;
    assign o_rsp.result_id    = r_rsp_rid;
    assign o_rsp.running_id   = r_rsp_run;
    assign o_rsp.switch_count = r_rsp_sw;
endmodule
